[sv/tmq_pkg.sv]
// ----------------------------------------------------------------------------
// tmq_pkg
// Types and constants shared by the timer expiry queue modules.
// ----------------------------------------------------------------------------
package tmq_pkg;

  // Slot field is four bits wide, so at most sixteen slots can be addressed.
  localparam int MAX_SLOTS = 16;

  // Input item packing on in_tdata, lowest bit first.
  localparam int IN_DATA_W   = 136;
  localparam int IN_SLOT_LSB = 0;
  localparam int IN_EXP_LSB  = 4;
  localparam int IN_NOW_LSB  = 68;

  // Result item packing on out_tdata.
  localparam int OUT_DATA_W = 72;

  typedef enum logic [1:0] {
    OP_ARM    = 2'd0,
    OP_DISARM = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ARM       = 2'd0,
    KIND_DISARM    = 2'd1,
    KIND_EXPIRED   = 2'd2,
    KIND_TICK_DONE = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DCHK     = 5'b00010,
    S_SCAN_MIN = 5'b00100,
    S_SCAN_SEL = 5'b01000,
    S_OUT      = 5'b10000
  } state_t;

  // Command to the slot scanner; the mode bits are sampled with start.
  typedef struct packed {
    logic start;
    logic sel_due;  // pick the earliest due slot rather than the minimum
    logic use_now;  // split slots into due and pending against the tick time
  } scan_cmd_t;

endpackage

[sv/tmq_ram.sv]
// ----------------------------------------------------------------------------
// tmq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tmq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/tmq_scan.sv]
// ----------------------------------------------------------------------------
// tmq_scan
// Walks the expiry RAM one slot a cycle and finds the earliest armed expiry,
// the earliest pending one (counting due slots), or the earliest due slot.
// ----------------------------------------------------------------------------
module tmq_scan
  import tmq_pkg::*;
#(
  parameter int NUM_SLOTS = 16,
  parameter int TIME_BITS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  scan_cmd_t                           cmd,
  input  logic [NUM_SLOTS-1:0]                armed,
  input  logic [TIME_BITS-1:0]                now,
  input  logic [TIME_BITS-1:0]                rdata,
  output logic                                re,
  output logic [$clog2(NUM_SLOTS)-1:0]        raddr,
  output logic                                done,
  output logic [TIME_BITS-1:0]                best,
  output logic [$clog2(NUM_SLOTS)-1:0]        best_idx,
  output logic [$clog2(((NUM_SLOTS < MAX_SLOTS) ? NUM_SLOTS : MAX_SLOTS) + 1)-1:0] due_cnt
);

  localparam int USABLE = (NUM_SLOTS < MAX_SLOTS) ? NUM_SLOTS : MAX_SLOTS;
  localparam int IDX_W  = $clog2(NUM_SLOTS);
  localparam int CNT_W  = $clog2(USABLE + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(USABLE - 1);

  logic                 issue_r;
  logic [IDX_W-1:0]     cnt_r;
  logic                 rd_vld_r;
  logic [IDX_W-1:0]     rd_idx_r;
  logic                 done_r;
  logic                 sel_r;
  logic                 use_now_r;
  logic                 found_r;
  logic [TIME_BITS-1:0] best_r;
  logic [IDX_W-1:0]     idx_r;
  logic [CNT_W-1:0]     due_r;

  logic hit_armed;
  logic le_now;
  logic due_hit;
  logic take;
  logic count_due;

  always_comb begin
    hit_armed = armed[rd_idx_r];
    le_now    = (rdata <= now);
    due_hit   = hit_armed && le_now;
    if (sel_r) begin
      // Ascending scan with a strict compare gives ties to the lower slot.
      take = due_hit && (!found_r || (rdata < best_r));
    end else begin
      take = hit_armed && (!use_now_r || !le_now) && (rdata < best_r);
    end
    count_due = !sel_r && use_now_r && due_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r  <= 1'b0;
      rd_vld_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      rd_vld_r <= issue_r;
      done_r   <= rd_vld_r && (rd_idx_r == LAST_IDX);
      if (cmd.start) begin
        issue_r <= 1'b1;
      end else if (issue_r && (cnt_r == LAST_IDX)) begin
        issue_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r;
    if (cmd.start) begin
      cnt_r     <= '0;
      best_r    <= '1;
      found_r   <= 1'b0;
      due_r     <= '0;
      sel_r     <= cmd.sel_due;
      use_now_r <= cmd.use_now;
    end else begin
      if (issue_r) begin
        cnt_r <= cnt_r + IDX_W'(1);
      end
      if (rd_vld_r) begin
        if (take) begin
          best_r  <= rdata;
          idx_r   <= rd_idx_r;
          found_r <= 1'b1;
        end
        if (count_due) begin
          due_r <= due_r + CNT_W'(1);
        end
      end
    end
  end

  assign re       = issue_r;
  assign raddr    = cnt_r;
  assign done     = done_r;
  assign best     = best_r;
  assign best_idx = idx_r;
  assign due_cnt  = due_r;

endmodule

[sv/timer_expiry_queue.sv]
// ----------------------------------------------------------------------------
// timer_expiry_queue
// Timer slots with armed flags and expiry times in RAM; arm, disarm and tick
// operations, with due timers reported in expiry order on each tick.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Contents
//  --------+----------------------+-------------------------------------------
//  in      | in_tvalid/in_tready  | tuser: operation; tdata: slot, expiry_time,
//          |                      | current_time
//  out     | out_tvalid/out_tready| tuser: kind; tlast: last; tdata: accepted,
//          |                      | expired_slot, next_deadline
//
// Arm completes straight from idle; disarm reads the slot's expiry and, when
// the earliest expiry must be found again, scans the RAM across the usable
// slot count (16 by default). A tick before the earliest expiry completes
// straight from idle; one that fires timers runs one RAM scan to find the new
// deadline and count due slots, then one scan per fired timer, each reading
// one slot a cycle through the RAM read port.
// Reset is synchronous, clears all armed flags and sets the deadline register to all ones.
// A stalled output holds the block in its output state; in_tready is high
// only when idle.
// ----------------------------------------------------------------------------
module timer_expiry_queue
  import tmq_pkg::*;
#(
  parameter int NUM_SLOTS = 16,
  parameter int TIME_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // slot, expiry_time, current_time
  input  logic [1:0]            in_tuser,   // operation
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // accepted, expired_slot, next_deadline
  output logic [1:0]            out_tuser,  // kind
  output logic                  out_tlast
);

  localparam int USABLE = (NUM_SLOTS < MAX_SLOTS) ? NUM_SLOTS : MAX_SLOTS;
  localparam int IDX_W  = $clog2(NUM_SLOTS);
  localparam int CNT_W  = $clog2(USABLE + 1);
  localparam logic [4:0] USABLE_LIM = 5'(USABLE);

  // Input fields
  op_t                  in_op;
  logic [3:0]           in_slot;
  logic [TIME_BITS-1:0] in_expiry;
  logic [TIME_BITS-1:0] in_now;
  logic [IDX_W-1:0]     in_idx;
  logic                 in_usable;

  // Control state
  state_t               state_r,    state_nxt;
  logic [NUM_SLOTS-1:0] armed_r,    armed_nxt;
  logic [TIME_BITS-1:0] earliest_r, earliest_nxt;
  logic [CNT_W-1:0]     due_r,      due_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Operation context and the result waiting to be loaded
  op_t                  op_r,    op_nxt;
  logic [TIME_BITS-1:0] now_r,   now_nxt;
  kind_t                pkind_r, pkind_nxt;
  logic                 pacc_r,  pacc_nxt;
  logic [3:0]           pslot_r, pslot_nxt;
  logic                 plast_r, plast_nxt;

  // Output register
  kind_t                okind_r;
  logic                 oacc_r;
  logic [3:0]           oslot_r;
  logic [TIME_BITS-1:0] odead_r;
  logic                 olast_r;
  logic                 load_out;

  // RAM and scanner wiring
  logic                 ram_we;
  logic                 ram_re;
  logic                 dis_re;
  logic [IDX_W-1:0]     ram_raddr;
  logic [TIME_BITS-1:0] ram_rdata;
  scan_cmd_t            scan_cmd;
  logic                 scan_re;
  logic [IDX_W-1:0]     scan_raddr;
  logic                 scan_done;
  logic [TIME_BITS-1:0] scan_best;
  logic [IDX_W-1:0]     scan_idx;
  logic [CNT_W-1:0]     scan_due;

  assign in_op     = op_t'(in_tuser);
  assign in_slot   = in_tdata[IN_SLOT_LSB +: 4];
  assign in_expiry = in_tdata[IN_EXP_LSB +: TIME_BITS];
  assign in_now    = in_tdata[IN_NOW_LSB +: TIME_BITS];
  assign in_idx    = IDX_W'(in_slot);
  assign in_usable = ({1'b0, in_slot} < USABLE_LIM);

  assign in_tready = (state_r == S_IDLE);

  tmq_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (NUM_SLOTS)
  ) u_expiry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_idx),
    .wdata (in_expiry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tmq_scan #(
    .NUM_SLOTS (NUM_SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (scan_cmd),
    .armed    (armed_r),
    .now      (now_r),
    .rdata    (ram_rdata),
    .re       (scan_re),
    .raddr    (scan_raddr),
    .done     (scan_done),
    .best     (scan_best),
    .best_idx (scan_idx),
    .due_cnt  (scan_due)
  );

  assign ram_re    = scan_re | dis_re;
  assign ram_raddr = scan_re ? scan_raddr : in_idx;

  always_comb begin
    state_nxt    = state_r;
    armed_nxt    = armed_r;
    earliest_nxt = earliest_r;
    due_nxt      = due_r;
    op_nxt       = op_r;
    now_nxt      = now_r;
    pkind_nxt    = pkind_r;
    pacc_nxt     = pacc_r;
    pslot_nxt    = pslot_r;
    plast_nxt    = plast_r;
    scan_cmd     = '0;
    ram_we       = 1'b0;
    dis_re       = 1'b0;
    load_out     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_op;
          now_nxt   = in_now;
          pacc_nxt  = 1'b0;
          pslot_nxt = '0;
          plast_nxt = 1'b1;
          state_nxt = S_OUT;
          unique case (in_op)
            OP_ARM: begin
              pkind_nxt = KIND_ARM;
              if (in_usable && !armed_r[in_idx]) begin
                ram_we            = 1'b1;
                armed_nxt[in_idx] = 1'b1;
                pacc_nxt          = 1'b1;
                if (in_expiry < earliest_r) begin
                  earliest_nxt = in_expiry;
                end
              end
            end
            OP_DISARM: begin
              pkind_nxt = KIND_DISARM;
              if (in_usable && armed_r[in_idx]) begin
                armed_nxt[in_idx] = 1'b0;
                pacc_nxt          = 1'b1;
                dis_re            = 1'b1;
                state_nxt         = S_DCHK;
              end
            end
            OP_TICK: begin
              pkind_nxt = KIND_TICK_DONE;
              if (in_now >= earliest_r) begin
                scan_cmd.start   = 1'b1;
                scan_cmd.use_now = 1'b1;
                state_nxt        = S_SCAN_MIN;
              end
            end
            default: begin
              pkind_nxt = KIND_TICK_DONE;
            end
          endcase
        end
      end

      S_DCHK: begin
        // Only a slot holding the earliest expiry forces a fresh search.
        if (ram_rdata == earliest_r) begin
          scan_cmd.start = 1'b1;
          state_nxt      = S_SCAN_MIN;
        end else begin
          state_nxt = S_OUT;
        end
      end

      S_SCAN_MIN: begin
        if (scan_done) begin
          earliest_nxt = scan_best;
          state_nxt    = S_OUT;
          if (op_r == OP_TICK) begin
            due_nxt = scan_due;
            if (scan_due != '0) begin
              scan_cmd.start   = 1'b1;
              scan_cmd.sel_due = 1'b1;
              state_nxt        = S_SCAN_SEL;
            end
          end
        end
      end

      S_SCAN_SEL: begin
        if (scan_done) begin
          armed_nxt[scan_idx] = 1'b0;
          due_nxt             = due_r - CNT_W'(1);
          pkind_nxt           = KIND_EXPIRED;
          pslot_nxt           = 4'(scan_idx);
          plast_nxt           = 1'b0;
          state_nxt           = S_OUT;
        end
      end

      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          load_out = 1'b1;
          if (plast_r) begin
            state_nxt = S_IDLE;
          end else if (due_r == '0) begin
            pkind_nxt = KIND_TICK_DONE;
            pslot_nxt = '0;
            plast_nxt = 1'b1;
          end else begin
            scan_cmd.start   = 1'b1;
            scan_cmd.sel_due = 1'b1;
            state_nxt        = S_SCAN_SEL;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = load_out | (out_valid_r & ~out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      armed_r     <= '0;
      earliest_r  <= '1;
      due_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      armed_r     <= armed_nxt;
      earliest_r  <= earliest_nxt;
      due_r       <= due_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    now_r   <= now_nxt;
    pkind_r <= pkind_nxt;
    pacc_r  <= pacc_nxt;
    pslot_r <= pslot_nxt;
    plast_r <= plast_nxt;
    if (load_out) begin
      okind_r <= pkind_r;
      oacc_r  <= pacc_r;
      oslot_r <= pslot_r;
      odead_r <= earliest_r;
      olast_r <= plast_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {3'b000, 64'(odead_r), oslot_r, oacc_r};

endmodule
